@@ rtl/core/ind_pkg.sv @@
// Shared types, widths and codes for the inward normal detector.
package ind_pkg;

    // Field widths
    localparam int COORD_BITS = 24;
    localparam int NORM_BITS  = 14;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int NAXES      = 3;

    // Stream data widths, padded to whole bytes
    localparam int IN_FIELDS_W = NAXES * COORD_BITS + NAXES * NORM_BITS;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Arithmetic widths of the back end
    localparam int MUL_W  = EXT_BITS;
    localparam int PROD_W = 2 * MUL_W;
    localparam int VOL_W  = 3 * MUL_W;
    localparam int PLN_W  = PROD_W + 9;

    // Queue geometry
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EXT_BITS-1:0]   ext_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [NORM_BITS-1:0]  norm_t;
    typedef logic [PROD_W-1:0]            prod_t;
    typedef logic [VOL_W-1:0]             vol_t;
    typedef logic [PLN_W-1:0]             pln_t;

    // Empty-box values
    localparam coord_t COORD_MAX_V = coord_t'((1 << (COORD_BITS - 1)) - 1);
    localparam coord_t COORD_MIN_V = coord_t'(1 << (COORD_BITS - 1));
    localparam ext_t   EXT_MAX_V   = ext_t'((1 << COORD_BITS) - 1);
    localparam ext_t   EXT_MIN_V   = ext_t'(1 << COORD_BITS);
    localparam sum_t   SUM_HI      = sum_t'((1 << COORD_BITS) - 1);
    localparam sum_t   SUM_LO      = -SUM_HI - sum_t'(1);

    // One finished mesh: plain and offset box extents
    typedef struct packed {
        logic [NAXES-1:0][EXT_BITS-1:0]   dq;
        logic [NAXES-1:0][COORD_BITS-1:0] dp;
    } ext_entry_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef enum logic [1:0] {
        VERDICT_FLAT_MISMATCH = 2'd0,
        VERDICT_PLANAR        = 2'd1,
        VERDICT_VOL_KEPT      = 2'd2,
        VERDICT_FLIP          = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_CMP
    } bk_state_t;

    // Multiplier schedule, one product per step
    typedef logic [3:0] step_t;
    localparam step_t ST_SQ0 = 4'd0;
    localparam step_t ST_SQ1 = 4'd1;
    localparam step_t ST_SQ2 = 4'd2;
    localparam step_t ST_BC0 = 4'd3;
    localparam step_t ST_BC1 = 4'd4;
    localparam step_t ST_BC2 = 4'd5;
    localparam step_t ST_Q01 = 4'd6;
    localparam step_t ST_VPL = 4'd7;
    localparam step_t ST_VPH = 4'd8;
    localparam step_t ST_VQL = 4'd9;
    localparam step_t ST_VQH = 4'd10;
    localparam int    MUL_STEPS = 11;
    localparam step_t MUL_LAST  = ST_VQH;

endpackage

@@ rtl/core/ind_front.sv @@
// Front end: per-vertex bounding box update and mesh snapshot.
module ind_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ind_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  ind_pkg::q_stat_t              q_stat,
    output logic                          q_push,
    output ind_pkg::ext_entry_t           q_wdata
);
    import ind_pkg::*;

    coord_t pmin_reg [NAXES];
    coord_t pmax_reg [NAXES];
    ext_t   omin_reg [NAXES];
    ext_t   omax_reg [NAXES];
    coord_t pmin_next [NAXES];
    coord_t pmax_next [NAXES];
    ext_t   omin_next [NAXES];
    ext_t   omax_next [NAXES];

    coord_t snap_pmin_reg [NAXES];
    coord_t snap_pmax_reg [NAXES];
    ext_t   snap_omin_reg [NAXES];
    ext_t   snap_omax_reg [NAXES];
    logic   snap_valid_reg;
    logic   snap_valid_next;

    coord_t pos [NAXES];
    norm_t  nrm [NAXES];
    sum_t   ofs_sum [NAXES];
    ext_t   ofs [NAXES];
    coord_t upd_pmin [NAXES];
    coord_t upd_pmax [NAXES];
    ext_t   upd_omin [NAXES];
    ext_t   upd_omax [NAXES];
    logic   accept;

    // Handshake: a new mesh end can be taken once the snapshot drains
    assign s_axis_tready = !snap_valid_reg || !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_push        = snap_valid_reg && !q_stat.full;

    // Field unpack, saturated offset sum and min/max update per axis
    always_comb
    begin
        for (int i = 0; i < NAXES; i++)
        begin
            pos[i] = coord_t'(s_axis_tdata[i*COORD_BITS +: COORD_BITS]);
            nrm[i] = norm_t'(s_axis_tdata[NAXES*COORD_BITS + i*NORM_BITS +: NORM_BITS]);
            ofs_sum[i] = sum_t'(pos[i]) + sum_t'(nrm[i]);
            if (ofs_sum[i] > SUM_HI)
                ofs[i] = EXT_MAX_V;
            else if (ofs_sum[i] < SUM_LO)
                ofs[i] = EXT_MIN_V;
            else
                ofs[i] = ext_t'(ofs_sum[i]);
            upd_pmin[i] = (pos[i] < pmin_reg[i]) ? pos[i] : pmin_reg[i];
            upd_pmax[i] = (pos[i] > pmax_reg[i]) ? pos[i] : pmax_reg[i];
            upd_omin[i] = (ofs[i] < omin_reg[i]) ? ofs[i] : omin_reg[i];
            upd_omax[i] = (ofs[i] > omax_reg[i]) ? ofs[i] : omax_reg[i];
        end
    end

    // Box next state: the last vertex empties the boxes for the next mesh
    always_comb
    begin
        for (int i = 0; i < NAXES; i++)
        begin
            pmin_next[i] = pmin_reg[i];
            pmax_next[i] = pmax_reg[i];
            omin_next[i] = omin_reg[i];
            omax_next[i] = omax_reg[i];
            if (accept && s_axis_tlast)
            begin
                pmin_next[i] = COORD_MAX_V;
                pmax_next[i] = COORD_MIN_V;
                omin_next[i] = EXT_MAX_V;
                omax_next[i] = EXT_MIN_V;
            end
            else if (accept)
            begin
                pmin_next[i] = upd_pmin[i];
                pmax_next[i] = upd_pmax[i];
                omin_next[i] = upd_omin[i];
                omax_next[i] = upd_omax[i];
            end
        end
        snap_valid_next = (snap_valid_reg && !q_push) || (accept && s_axis_tlast);
    end

    // Extents of the finished mesh go to the queue
    always_comb
    begin
        for (int i = 0; i < NAXES; i++)
        begin
            q_wdata.dp[i] = snap_pmax_reg[i] - snap_pmin_reg[i];
            q_wdata.dq[i] = snap_omax_reg[i] - snap_omin_reg[i];
        end
    end

    // Box and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAXES; i++)
            begin
                pmin_reg[i] <= COORD_MAX_V;
                pmax_reg[i] <= COORD_MIN_V;
                omin_reg[i] <= EXT_MAX_V;
                omax_reg[i] <= EXT_MIN_V;
            end
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NAXES; i++)
            begin
                pmin_reg[i] <= pmin_next[i];
                pmax_reg[i] <= pmax_next[i];
                omin_reg[i] <= omin_next[i];
                omax_reg[i] <= omax_next[i];
            end
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            for (int i = 0; i < NAXES; i++)
            begin
                snap_pmin_reg[i] <= upd_pmin[i];
                snap_pmax_reg[i] <= upd_pmax[i];
                snap_omin_reg[i] <= upd_omin[i];
                snap_omax_reg[i] <= upd_omax[i];
            end
        end
    end

    // A held snapshot is never overwritten
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && q_stat.full) |-> !accept)
        else $error("mesh snapshot overwritten while queue full");

endmodule

@@ rtl/core/ind_queue.sv @@
// Short queue of mesh extents between front and back end.
module ind_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ind_pkg::ext_entry_t wdata,
    input  logic                pop,
    output ind_pkg::q_stat_t    q_stat,
    output ind_pkg::ext_entry_t head
);
    import ind_pkg::*;

    ext_entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QDEPTH)) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue underflow");

endmodule

@@ rtl/core/ind_back.sv @@
// Back end: flatness, planarity and volume tests on one mesh, one product a cycle.
module ind_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ind_pkg::q_stat_t               q_stat,
    input  ind_pkg::ext_entry_t            q_head,
    output logic                           q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ind_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ind_pkg::*;

    bk_state_t state_reg;
    bk_state_t state_next;
    step_t     step_reg;
    step_t     step_next;

    prod_t     prod_reg [MUL_STEPS];
    logic      planar_reg;
    logic      planar_next;
    vol_t      vp_reg;
    vol_t      vq_reg;
    vol_t      vp_next;
    vol_t      vq_next;
    verdict_t  verdict_reg;
    verdict_t  verdict_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    logic [MUL_W-1:0] dp_w [NAXES];
    logic [MUL_W-1:0] dq_w [NAXES];
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
    prod_t            mul_p;
    pln_t             sq400 [NAXES];
    logic             flat_mis;

    logic mul_en;
    logic sum_en;
    logic out_load;
    logic out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(verdict_reg);

    // Extents widened to the multiplier operand width
    always_comb
    begin
        for (int i = 0; i < NAXES; i++)
        begin
            dp_w[i] = MUL_W'(q_head.dp[i]);
            dq_w[i] = q_head.dq[i];
        end
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_SQ0:  begin mul_a = dp_w[0]; mul_b = dp_w[0]; end
            ST_SQ1:  begin mul_a = dp_w[1]; mul_b = dp_w[1]; end
            ST_SQ2:  begin mul_a = dp_w[2]; mul_b = dp_w[2]; end
            ST_BC0:  begin mul_a = dp_w[1]; mul_b = dp_w[2]; end
            ST_BC1:  begin mul_a = dp_w[2]; mul_b = dp_w[0]; end
            ST_BC2:  begin mul_a = dp_w[0]; mul_b = dp_w[1]; end
            ST_Q01:  begin mul_a = dq_w[0]; mul_b = dq_w[1]; end
            ST_VPL:  begin mul_a = prod_reg[ST_BC2][MUL_W-1:0];      mul_b = dp_w[2]; end
            ST_VPH:  begin mul_a = prod_reg[ST_BC2][PROD_W-1:MUL_W]; mul_b = dp_w[2]; end
            ST_VQL:  begin mul_a = prod_reg[ST_Q01][MUL_W-1:0];      mul_b = dq_w[2]; end
            ST_VQH:  begin mul_a = prod_reg[ST_Q01][PROD_W-1:MUL_W]; mul_b = dq_w[2]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Planarity (400*a*a < b*c, 400 = 256+128+16) and volume assembly
    always_comb
    begin
        planar_next = 1'b0;
        for (int i = 0; i < NAXES; i++)
        begin
            sq400[i] = (PLN_W'(prod_reg[int'(ST_SQ0) + i]) << 8)
                     + (PLN_W'(prod_reg[int'(ST_SQ0) + i]) << 7)
                     + (PLN_W'(prod_reg[int'(ST_SQ0) + i]) << 4);
            planar_next = planar_next
                        || (sq400[i] < PLN_W'(prod_reg[int'(ST_BC0) + i]));
        end
        vp_next = (VOL_W'(prod_reg[ST_VPH]) << MUL_W) + VOL_W'(prod_reg[ST_VPL]);
        vq_next = (VOL_W'(prod_reg[ST_VQH]) << MUL_W) + VOL_W'(prod_reg[ST_VQL]);
    end

    // Verdict in priority order
    always_comb
    begin
        flat_mis = 1'b0;
        for (int i = 0; i < NAXES; i++)
            flat_mis = flat_mis || ((q_head.dp[i] != '0) != (q_head.dq[i] != '0));
        if (flat_mis)
            verdict_next = VERDICT_FLAT_MISMATCH;
        else if (planar_reg)
            verdict_next = VERDICT_PLANAR;
        else if (!(vq_reg < vp_reg))
            verdict_next = VERDICT_VOL_KEPT;
        else
            verdict_next = VERDICT_FLIP;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_stat.valid)
                    state_next = BK_MUL;
            BK_MUL:
                if (step_reg == MUL_LAST)
                    state_next = BK_SUM;
            BK_SUM:
                state_next = BK_CMP;
            BK_CMP:
                if (out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        mul_en   = 1'b0;
        sum_en   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_MUL:  mul_en = 1'b1;
            BK_SUM:  sum_en = 1'b1;
            BK_CMP:  out_load = out_free;
            default: mul_en = 1'b0;
        endcase
        q_pop          = out_load;
        step_next      = (mul_en && step_reg != MUL_LAST) ? step_reg + 1'b1 : '0;
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg[step_reg] <= mul_p;
        if (sum_en)
        begin
            planar_reg <= planar_next;
            vp_reg     <= vp_next;
            vq_reg     <= vq_next;
        end
        if (out_load)
            verdict_reg <= verdict_next;
    end

    a_head_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> q_stat.valid)
        else $error("back end running without a queued mesh");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MUL) |-> (step_reg <= MUL_LAST))
        else $error("multiplier step out of schedule");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == BK_CMP))
        else $error("result raised outside the compare step");

endmodule

@@ rtl/core/inward_normal_detector_unit.sv @@
// Throughput: one vertex per cycle while s_axis_tready is high; the back end's shared
// 25x25 multiplier works on one mesh at a time, so short meshes back up through a
// 2-entry queue.
// Reset: rst_n (asynchronous, active low) empties both boxes, the queue and the
// sequencer; s_axis_tready is already high when reset is released.
module inward_normal_detector_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, zero pad
    input  logic [ind_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // last_vertex
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // verdict, zero pad
    output logic [ind_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ind_pkg::*;

    q_stat_t    q_stat;
    logic       q_push;
    logic       q_pop;
    ext_entry_t q_wdata;
    ext_entry_t q_head;

    // Vertex intake and box tracking
    ind_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    // Mesh extents queue
    ind_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .q_stat (q_stat),
        .head   (q_head)
    );

    // Verdict computation
    ind_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
